// File: hdl/rmq_pkg.sv
// shared widths, word types and helpers for the rotation matrix to quaternion block
package rmq_pkg;

  localparam int DW   = 16;
  localparam int FB   = DW - 2;
  localparam int RADW = DW + 2;
  localparam int SQW  = 2 * DW;
  localparam int RTW  = DW;
  localparam int NUMW = DW + 1;
  localparam int LAT  = RTW + DW + 2;

  localparam logic [DW-1:0] Q_ONE = DW'(64'd1 << FB);
  localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [1:0] {
    SEL_POS,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef struct packed {
    logic                   valid;
    sel_t                   sel;
    logic                   degen;
    logic signed [NUMW-1:0] n0;
    logic signed [NUMW-1:0] n1;
    logic signed [NUMW-1:0] n2;
    logic [SQW-1:0]         nrad;
    logic [RTW+1:0]         rem;
    logic [RTW-1:0]         root;
  } sq_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [RTW:0]   rem;
    logic [DW-1:0]  low;
    logic [DW-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic           valid;
    sel_t           sel;
    logic           degen;
    logic [RTW-1:0] root;
    logic [RTW:0]   den;
    lane_t          l0;
    lane_t          l1;
    lane_t          l2;
  } dv_t;

  function automatic lane_t lane_init(logic signed [NUMW-1:0] num, logic [RTW:0] den);
    logic [NUMW-1:0]    mag;
    logic [NUMW+FB-1:0] dvd;
    lane_t              l;
    mag   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    dvd   = {mag, {FB{1'b0}}};
    l.neg = num[NUMW-1];
    l.ovf = (RTW+1)'(dvd >> DW) >= den;
    l.rem = (RTW+1)'(dvd >> DW);
    l.low = dvd[DW-1:0];
    l.quo = '0;
    return l;
  endfunction

  function automatic word_t lane_final(lane_t l);
    word_t r;
    if (!l.neg) begin
      r = (l.ovf || l.quo > Q_MAX) ? Q_MAX : l.quo;
    end else begin
      r = (l.ovf || l.quo > Q_MIN) ? Q_MIN : DW'(-l.quo);
    end
    return r;
  endfunction

endpackage

// File: hdl/rmq_front.sv
// input stage: trace, pivot choice, radicand and numerators
module rmq_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  rmq_pkg::word_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output rmq_pkg::sq_t q
);
  import rmq_pkg::*;

  logic signed [RADW-1:0] trace, rad, a00, a11, a22, one;
  sq_t s_nxt, s_r;

  always_comb begin
    a00   = RADW'(m00);
    a11   = RADW'(m11);
    a22   = RADW'(m22);
    one   = RADW'(Q_ONE);
    trace = a00 + a11 + a22;
    s_nxt = '0;
    s_nxt.valid = take;
    if (trace > 0) begin
      s_nxt.sel = SEL_POS;
      rad = trace + one;
      s_nxt.n0 = NUMW'(m21) - NUMW'(m12);
      s_nxt.n1 = NUMW'(m02) - NUMW'(m20);
      s_nxt.n2 = NUMW'(m10) - NUMW'(m01);
    end else if (m22 > ((m11 > m00) ? m11 : m00)) begin
      s_nxt.sel = SEL_Z;
      rad = a22 - a00 - a11 + one;
      s_nxt.n0 = NUMW'(m02) + NUMW'(m20);
      s_nxt.n1 = NUMW'(m12) + NUMW'(m21);
      s_nxt.n2 = NUMW'(m10) - NUMW'(m01);
    end else if (m11 > m00) begin
      s_nxt.sel = SEL_Y;
      rad = a11 - a22 - a00 + one;
      s_nxt.n0 = NUMW'(m21) + NUMW'(m12);
      s_nxt.n1 = NUMW'(m01) + NUMW'(m10);
      s_nxt.n2 = NUMW'(m02) - NUMW'(m20);
    end else begin
      s_nxt.sel = SEL_X;
      rad = a00 - a11 - a22 + one;
      s_nxt.n0 = NUMW'(m10) + NUMW'(m01);
      s_nxt.n1 = NUMW'(m20) + NUMW'(m02);
      s_nxt.n2 = NUMW'(m21) - NUMW'(m12);
    end
    s_nxt.degen = (rad <= 0);
    s_nxt.nrad  = s_nxt.degen ? '0 : (SQW'(unsigned'(rad)) << FB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign q = s_r;

endmodule

// File: hdl/rmq_sqrt_cell.sv
// one digit of the square root chain
module rmq_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  rmq_pkg::sq_t d,
  output rmq_pkg::sq_t q
);
  import rmq_pkg::*;

  logic [RTW+3:0] rem_w, trial;
  sq_t s_nxt, s_r;

  always_comb begin
    s_nxt = d;
    rem_w = {d.rem, d.nrad[SQW-1:SQW-2]};
    trial = (RTW+4)'({d.root, 2'b01});
    s_nxt.nrad = d.nrad << 2;
    if (rem_w >= trial) begin
      s_nxt.rem  = (RTW+2)'(rem_w - trial);
      s_nxt.root = {d.root[RTW-2:0], 1'b1};
    end else begin
      s_nxt.rem  = (RTW+2)'(rem_w);
      s_nxt.root = {d.root[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign q = s_r;

endmodule

// File: hdl/rmq_div_cell.sv
// one quotient bit for each of the three division lanes
module rmq_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  rmq_pkg::dv_t d,
  output rmq_pkg::dv_t q
);
  import rmq_pkg::*;

  dv_t s_nxt, s_r;

  function automatic lane_t step(lane_t l, logic [RTW:0] den);
    logic [RTW+1:0] rw;
    lane_t          o;
    o   = l;
    rw  = {l.rem, l.low[DW-1]};
    o.low = l.low << 1;
    if (rw >= {1'b0, den}) begin
      o.rem = (RTW+1)'(rw - {1'b0, den});
      o.quo = {l.quo[DW-2:0], 1'b1};
    end else begin
      o.rem = rw[RTW:0];
      o.quo = {l.quo[DW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    s_nxt    = d;
    s_nxt.l0 = step(d.l0, d.den);
    s_nxt.l1 = step(d.l1, d.den);
    s_nxt.l2 = step(d.l2, d.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign q = s_r;

endmodule

// File: hdl/rotation_matrix_to_quaternion_top.sv
// top level: rotation matrix to quaternion, Shepperd's method in Q2.14
//
// start with the nine matrix elements on in_m00..in_m22 hands over one word;
// busy is always low, so a word is taken on every cycle that start is high.
// the word runs through an input stage, a chain of 16 square root cells
// (one root bit per cell), a chain of 16 division cells (one quotient bit
// per cell, three lanes side by side) and an output register.
// throughput is one word per cycle, words leave in the order they came.
// out_valid is high for exactly one cycle per word with out_q_w..out_q_z
// and out_degenerate; the receiver cannot stall, so it must take the word
// in that cycle.
// out_degenerate marks a non-positive radicand; the identity is returned.
// synchronous reset (rst_n low) drops every word in flight; out_valid is
// low during and after reset until new words arrive.
module rotation_matrix_to_quaternion_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rmq_pkg::word_t in_m00, in_m01, in_m02,
  input  rmq_pkg::word_t in_m10, in_m11, in_m12,
  input  rmq_pkg::word_t in_m20, in_m21, in_m22,
  output logic           out_valid,
  output rmq_pkg::word_t out_q_w,
  output rmq_pkg::word_t out_q_x,
  output rmq_pkg::word_t out_q_y,
  output rmq_pkg::word_t out_q_z,
  output logic           out_degenerate
);
  import rmq_pkg::*;

  sq_t   sq [RTW+1];
  dv_t   dv [DW+1];
  word_t half, d0, d1, d2;
  word_t w_nxt, x_nxt, y_nxt, z_nxt;
  word_t w_r, x_r, y_r, z_r;
  logic  valid_r, degen_r;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk(clk), .rst_n(rst_n), .take(start && !busy),
    .m00(in_m00), .m01(in_m01), .m02(in_m02),
    .m10(in_m10), .m11(in_m11), .m12(in_m12),
    .m20(in_m20), .m21(in_m21), .m22(in_m22),
    .q(sq[0])
  );

  for (genvar g = 0; g < RTW; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (.clk(clk), .rst_n(rst_n), .d(sq[g]), .q(sq[g+1]));
  end

  always_comb begin
    dv[0].valid = sq[RTW].valid;
    dv[0].sel   = sq[RTW].sel;
    dv[0].degen = sq[RTW].degen;
    dv[0].root  = sq[RTW].root;
    dv[0].den   = {sq[RTW].root, 1'b0};
    dv[0].l0    = lane_init(sq[RTW].n0, {sq[RTW].root, 1'b0});
    dv[0].l1    = lane_init(sq[RTW].n1, {sq[RTW].root, 1'b0});
    dv[0].l2    = lane_init(sq[RTW].n2, {sq[RTW].root, 1'b0});
  end

  for (genvar g = 0; g < DW; g++) begin : g_div
    rmq_div_cell u_cell (.clk(clk), .rst_n(rst_n), .d(dv[g]), .q(dv[g+1]));
  end

  always_comb begin
    half = DW'(dv[DW].root >> 1);
    d0   = lane_final(dv[DW].l0);
    d1   = lane_final(dv[DW].l1);
    d2   = lane_final(dv[DW].l2);
    unique case (dv[DW].sel)
      SEL_POS: begin w_nxt = half; x_nxt = d0;   y_nxt = d1;   z_nxt = d2;   end
      SEL_X:   begin w_nxt = d2;   x_nxt = half; y_nxt = d0;   z_nxt = d1;   end
      SEL_Y:   begin w_nxt = d2;   x_nxt = d1;   y_nxt = half; z_nxt = d0;   end
      SEL_Z:   begin w_nxt = d2;   x_nxt = d0;   y_nxt = d1;   z_nxt = half; end
      default: begin w_nxt = half; x_nxt = d0;   y_nxt = d1;   z_nxt = d2;   end
    endcase
    if (dv[DW].degen) begin
      w_nxt = Q_ONE;
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    degen_r <= dv[DW].degen;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv[DW].valid;
    end
  end

  assign out_valid      = valid_r;
  assign out_q_w        = w_r;
  assign out_q_x        = x_r;
  assign out_q_y        = y_r;
  assign out_q_z        = z_r;
  assign out_degenerate = degen_r;

endmodule

// File: hdl/rmq_checker.sv
// port checker for the rotation matrix to quaternion block, with its bind
module rmq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input rmq_pkg::word_t out_q_w,
  input rmq_pkg::word_t out_q_x,
  input rmq_pkg::word_t out_q_y,
  input rmq_pkg::word_t out_q_z,
  input logic           out_degenerate
);
  import rmq_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("word out without a word in");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_q_w == Q_ONE && out_q_x == '0 && out_q_y == '0 && out_q_z == '0)
    else $error("degenerate word is not the identity");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && $past(rst_n, LAT) |-> ##LAT out_valid)
    else $error("word lost");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
